/* hdl/psb_pkg.sv */
// ----------------------------------------------------------------------------
// psb_pkg
// Types and constants shared by the poll scheduler controller and datapath.
// ----------------------------------------------------------------------------
package psb_pkg;

  localparam int NUM_FEEDS    = 7;
  localparam int FEED_W       = 3;
  localparam int TIME_W       = 32;
  localparam int BASE_W       = 25;
  localparam int SCALE_W      = 8;
  localparam int CP_INTV_W    = 22;
  localparam int FAIL_W       = 4;
  localparam int SHIFT_W      = 3;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 22;

  localparam logic [FEED_W-1:0]  CMDPOST_FEED    = 3'd6;
  localparam logic [FEED_W-1:0]  LAST_FEED       = 3'd6;
  localparam logic [SCALE_W-1:0] SCALE_MIN       = 8'd16;
  localparam logic [SCALE_W-1:0] SCALE_MAX       = 8'd128;
  localparam logic [FAIL_W-1:0]  FAIL_MAX        = 4'd15;
  localparam logic [SHIFT_W-1:0] MAX_SHIFT       = 3'd5;
  localparam logic [TIME_W-1:0]  BACKOFF_CAP_MS  = 32'd600000;
  localparam logic [CP_INTV_W-1:0] CP_INTV_RESET = 22'd60000;

  typedef enum logic [1:0] {
    OP_POLL     = 2'd0,
    OP_COMPLETE = 2'd1,
    OP_RESTART  = 2'd2
  } psb_op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE   = 2'd0,
    REG_CP_INTV = 2'd1,
    REG_CP_EN   = 2'd2
  } psb_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH,
    ST_RESTART,
    ST_COMPLETE
  } psb_state_t;

  // base intervals at scale one; the command-post entry is its reset value
  localparam logic [BASE_W-1:0] BASE_MS [NUM_FEEDS] = '{
    25'd30000, 25'd60000, 25'd300000, 25'd300000,
    25'd1800000, 25'd21600000, 25'd60000
  };

  // first due offsets after restart: 400 ms apart, 300 ms in
  localparam logic [11:0] STAGGER_MS [NUM_FEEDS] = '{
    12'd300, 12'd700, 12'd1100, 12'd1500, 12'd1900, 12'd2300, 12'd2700
  };

  typedef struct packed {
    logic latch;
    logic scan;
    logic restart;
    logic complete;
    logic rearm;
    logic push;
  } psb_cmd_t;

  typedef struct packed {
    psb_op_t in_op;
    logic    flight;
    logic    last;
    logic    found;
    logic    inert;
    logic    out_free;
  } psb_stat_t;

endpackage

/* hdl/psb_if.sv */
// ----------------------------------------------------------------------------
// psb_if
// Valid/ready channels of the poll scheduler: request items and dispatches.
// ----------------------------------------------------------------------------
interface psb_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] now_ms;
  logic [2:0]  feed_index;
  logic        fetch_ok;

  modport source (output valid, command, now_ms, feed_index, fetch_ok, input ready);
  modport sink   (input valid, command, now_ms, feed_index, fetch_ok, output ready);
endinterface

interface psb_disp_if;
  logic       valid;
  logic       ready;
  logic [2:0] dispatch_feed;

  modport source (output valid, dispatch_feed, input ready);
  modport sink   (input valid, dispatch_feed, output ready);
endinterface

/* hdl/psb_ctrl.sv */
// ----------------------------------------------------------------------------
// psb_ctrl
// Sequencer: accepts an item, then steps the datapath through scan, restart
// or completion.
// ----------------------------------------------------------------------------
module psb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  psb_pkg::psb_stat_t stat,
  output psb_pkg::psb_cmd_t  cmd
);
  import psb_pkg::*;

  psb_state_t state, state_next;
  logic       accept;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          unique case (stat.in_op)
            OP_RESTART:  state_next = ST_RESTART;
            OP_COMPLETE: state_next = ST_COMPLETE;
            OP_POLL:     state_next = stat.flight ? ST_IDLE : ST_SCAN;
            default:     state_next = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.last) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!stat.found) begin
          state_next = ST_IDLE;
        end else if (stat.inert) begin
          cmd.rearm  = 1'b1;
          state_next = ST_IDLE;
        end else if (stat.out_free) begin
          cmd.push   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_RESTART: begin
        cmd.restart = 1'b1;
        if (stat.last) state_next = ST_IDLE;
      end
      ST_COMPLETE: begin
        cmd.complete = 1'b1;
        state_next   = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  a_poll_starts_scan: assert property (@(posedge clk) disable iff (rst)
    (accept && stat.in_op == OP_POLL && !stat.flight) |=> state == ST_SCAN)
    else $error("poll with gate open did not start a scan");

  a_scan_runs_on: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && !stat.last) |=> state == ST_SCAN)
    else $error("scan left early");

  a_push_needs_found: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> (stat.found && !stat.inert))
    else $error("dispatch without a due feed");

endmodule

/* hdl/psb_datapath.sv */
// ----------------------------------------------------------------------------
// psb_datapath
// Per-feed due times, intervals and fail counts, the earliest-due search,
// interval scaling, backoff and the output register.
// ----------------------------------------------------------------------------
module psb_datapath (
  input  logic               clk,
  input  logic               rst,
  input  logic [1:0]         command,
  input  logic [31:0]        now_ms,
  input  logic [2:0]         feed_index,
  input  logic               fetch_ok,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [21:0]        cfg_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         dispatch_feed,
  input  psb_pkg::psb_cmd_t  cmd,
  output psb_pkg::psb_stat_t stat
);
  import psb_pkg::*;

  logic [TIME_W-1:0]    due  [NUM_FEEDS];
  logic [TIME_W-1:0]    intv [NUM_FEEDS];
  logic [FAIL_W-1:0]    fails[NUM_FEEDS];
  logic                 flight;

  logic [SCALE_W-1:0]   cfg_scale;
  logic [CP_INTV_W-1:0] cfg_cp_intv;
  logic                 cfg_cp_en;

  logic [TIME_W-1:0]    now_r;
  logic [FEED_W-1:0]    idx_r;
  logic                 ok_r;
  logic [FEED_W-1:0]    slot;
  logic [FEED_W-1:0]    best;
  logic [TIME_W-1:0]    best_due;
  logic                 found;

  logic [FEED_W-1:0]    rd_idx;
  logic [TIME_W-1:0]    due_rd;
  logic [TIME_W-1:0]    intv_rd;
  logic [FAIL_W-1:0]    fails_rd;
  logic [TIME_W-1:0]    age;
  logic [TIME_W-1:0]    lead;
  logic                 is_due;
  logic                 better;
  logic [SCALE_W-1:0]   scale;
  logic [BASE_W-1:0]    base_sel;
  logic [BASE_W+SCALE_W-1:0] prod;
  logic [FAIL_W-1:0]    fails_inc;
  logic [SHIFT_W-1:0]   shift;
  logic [TIME_W+4:0]    backoff_w;
  logic [TIME_W-1:0]    backoff;
  logic                 idx_ok;

  assign rd_idx   = cmd.complete ? idx_r : slot;
  assign due_rd   = due[rd_idx];
  assign intv_rd  = intv[rd_idx];
  assign fails_rd = fails[rd_idx];

  assign age    = now_r - due_rd;
  assign lead   = due_rd - best_due;
  assign is_due = !age[TIME_W-1];
  assign better = !found || lead[TIME_W-1];

  always_comb begin
    if (cfg_scale < SCALE_MIN)      scale = SCALE_MIN;
    else if (cfg_scale > SCALE_MAX) scale = SCALE_MAX;
    else                            scale = cfg_scale;
  end

  assign base_sel = (slot == CMDPOST_FEED) ? BASE_W'(cfg_cp_intv) : BASE_MS[slot];
  assign prod     = base_sel * scale;

  assign fails_inc = (fails_rd == FAIL_MAX) ? FAIL_MAX : fails_rd + 4'd1;
  assign shift     = (fails_inc > FAIL_W'(MAX_SHIFT)) ? MAX_SHIFT : fails_inc[SHIFT_W-1:0];
  assign backoff_w = {5'd0, intv_rd} << shift;
  assign backoff   = (backoff_w > (TIME_W+5)'(BACKOFF_CAP_MS)) ? BACKOFF_CAP_MS
                                                               : backoff_w[TIME_W-1:0];
  assign idx_ok    = (idx_r != 3'(NUM_FEEDS));

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_scale   <= SCALE_MIN;
      cfg_cp_intv <= CP_INTV_RESET;
      cfg_cp_en   <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCALE:   cfg_scale   <= cfg_data[SCALE_W-1:0];
        REG_CP_INTV: cfg_cp_intv <= cfg_data;
        REG_CP_EN:   cfg_cp_en   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // item capture and search state
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      now_r <= now_ms;
      idx_r <= feed_index;
      ok_r  <= fetch_ok;
    end
    if (cmd.scan && is_due && better) best_due <= due_rd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot  <= '0;
      best  <= '0;
      found <= 1'b0;
    end else if (cmd.latch) begin
      slot  <= '0;
      found <= 1'b0;
    end else if (cmd.scan || cmd.restart) begin
      slot <= slot + 3'd1;
      if (cmd.scan && is_due && better) begin
        found <= 1'b1;
        best  <= slot;
      end
    end
  end

  // per-feed tables
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_FEEDS; i++) begin
        due[i]   <= '0;
        intv[i]  <= TIME_W'(BASE_MS[i]);
        fails[i] <= '0;
      end
    end else if (cmd.restart) begin
      due[slot]   <= now_r + TIME_W'(STAGGER_MS[slot]);
      intv[slot]  <= TIME_W'(prod >> 4);
      fails[slot] <= '0;
    end else if (cmd.complete && idx_ok) begin
      if (ok_r) begin
        fails[idx_r] <= '0;
        due[idx_r]   <= now_r + intv_rd;
      end else begin
        fails[idx_r] <= fails_inc;
        due[idx_r]   <= now_r + backoff;
      end
    end else if (cmd.rearm) begin
      due[CMDPOST_FEED] <= now_r + intv[CMDPOST_FEED];
    end
  end

  // gate and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      flight    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.push)          flight <= 1'b1;
      else if (cmd.complete) flight <= 1'b0;
      if (cmd.push)          out_valid <= 1'b1;
      else if (out_ready)    out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) dispatch_feed <= best;
  end

  always_comb begin
    stat.in_op    = psb_op_t'(command);
    stat.flight   = flight;
    stat.last     = (slot == LAST_FEED);
    stat.found    = found;
    stat.inert    = (best == CMDPOST_FEED) && !cfg_cp_en;
    stat.out_free = !out_valid || out_ready;
  end

  a_push_free: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> (!out_valid || out_ready))
    else $error("result overwritten before it was taken");

  a_flight_from_push: assert property (@(posedge clk) disable iff (rst)
    $rose(flight) |-> $past(cmd.push))
    else $error("gate closed without a dispatch");

  a_result_gates: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> flight)
    else $error("dispatch shown with gate open");

endmodule

/* hdl/poll_scheduler_with_backoff_core.sv */
// ----------------------------------------------------------------------------
// poll_scheduler_with_backoff_core
// Earliest-due scheduler for seven feeds with one fetch in flight and
// exponential backoff on failure.
//
// Items arrive on the poll channel: command 0 polls, 1 reports a completed
// fetch (feed_index, fetch_ok), 2 restarts with scaled intervals and staggered
// due times. A poll that finds a due feed while no fetch is in flight puts the
// feed index on the dispatch channel, except a disabled command-post feed,
// which is only re-armed; all other items give no result.
// A poll with the gate open searches every feed, then decides, waiting while
// the dispatch register is full; a restart does one interval multiply per
// feed in a shared unit. Completions and gate-closed polls run no search.
// A dispatch is registered after the search and decision states. The dispatch
// register holds a result until taken; only a further dispatch waits for it.
// Scale and command-post interval writes (cfg_we/cfg_index/cfg_data) take
// effect at the next restart, the command-post enable at once. Reset gives the
// base intervals at scale one, all due times zero and the gate open.
// ----------------------------------------------------------------------------
module poll_scheduler_with_backoff_core (
  input  logic         clk,
  input  logic         rst,
  psb_req_if.sink      poll,
  psb_disp_if.source   dispatch,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [21:0]  cfg_data
);
  import psb_pkg::*;

  psb_cmd_t  cmd;
  psb_stat_t stat;

  psb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (poll.valid),
    .in_ready (poll.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  psb_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .command       (poll.command),
    .now_ms        (poll.now_ms),
    .feed_index    (poll.feed_index),
    .fetch_ok      (poll.fetch_ok),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (dispatch.valid),
    .out_ready     (dispatch.ready),
    .dispatch_feed (dispatch.dispatch_feed),
    .cmd           (cmd),
    .stat          (stat)
  );

endmodule
